@@ rtl/mlbt_pkg.sv @@
`default_nettype none
package mlbt_pkg;

  localparam int unsigned MaxLeds = 4;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_SET_ON   = 3'd1,
    OP_SET_OFF  = 3'd2,
    OP_START    = 3'd3,
    OP_STOP     = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  led_index;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
    logic [23:0] timeout_ticks;
  } cmd_t;

  typedef struct packed {
    logic [MaxLeds-1:0] pin_levels;
    logic [MaxLeds-1:0] blink_flags;
    logic               bad_index;
  } status_t;

endpackage
`default_nettype wire

@@ rtl/multi_led_blink_timer.sv @@
// Blink controller for up to four LEDs.
// cmd channel (valid/ready): one word per tick or per command (set on, set off,
// start blinking, stop blinking) addressed by led_index. A tick advances every
// blinking LED at once; a command touches only the LED it names. A command
// naming an LED at or above LED_COUNT changes nothing and reports bad_index.
// status channel (valid/ready): exactly one word per cmd word, in order,
// holding pin levels and blink flags after the operation.
// An accepted word's result is registered into the buffer and drives status
// once earlier results are taken. Throughput: one word per cycle while cmd_ready
// is high. All LED updates are combinational logic (an add, subtracts and
// compares per LED) from the state registers into the result buffer.
// The result side is a two-word buffer, so cmd_ready stays high while one
// result waits; when the receiver stalls with two words held, cmd_ready drops
// until a word is taken.
// Reset (rst, synchronous): all LEDs off, no blinking, result buffer empty.
`default_nettype none
module multi_led_blink_timer
  import mlbt_pkg::*;
#(
  parameter int unsigned LED_COUNT = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cmd_valid,
  output logic         cmd_ready,
  input  wire cmd_t    cmd,
  output logic         status_valid,
  input  wire logic    status_ready,
  output status_t      status
);

  localparam logic [3:0] LedLimit = 4'(LED_COUNT);

  logic                 push;
  logic                 pop;
  logic [1:0]           fill;
  status_t              head;
  status_t              skid;
  status_t              result;
  logic                 bad;
  logic                 is_cmd;

  logic [LED_COUNT-1:0] pin_q;
  logic [LED_COUNT-1:0] steady_q;
  logic [LED_COUNT-1:0] active_q;
  logic [LED_COUNT-1:0] pin_vec_next;
  logic [LED_COUNT-1:0] active_vec_next;

  assign cmd_ready    = (fill != 2'd2);
  assign push         = cmd_valid && cmd_ready;
  assign status_valid = (fill != 2'd0);
  assign pop          = status_valid && status_ready;
  assign status       = head;

  assign is_cmd = (cmd.operation == OP_SET_ON) || (cmd.operation == OP_SET_OFF) ||
                  (cmd.operation == OP_START) || (cmd.operation == OP_STOP);
  assign bad    = is_cmd && ({1'b0, cmd.led_index} >= LedLimit);

  for (genvar i = 0; i < LED_COUNT; i++) begin : g_led
    logic        steady, steady_next;
    logic        pin, pin_next;
    logic        active, active_next;
    logic        phase_on, phase_on_next;
    logic [15:0] on_len, on_len_next;
    logic [15:0] off_len, off_len_next;
    logic [23:0] limit, limit_next;
    logic [24:0] elapsed, elapsed_next;
    logic [15:0] countdown, countdown_next;
    logic        sel;
    logic [15:0] cur_len;
    logic [15:0] nxt_len;
    logic [25:0] sum;
    logic [24:0] sat;
    logic [23:0] left;
    logic [15:0] on_fix;
    logic [15:0] off_fix;

    assign sel     = (cmd.led_index == 3'(i));
    assign cur_len = phase_on ? on_len : off_len;
    assign nxt_len = phase_on ? off_len : on_len;
    assign sum     = {1'b0, elapsed} + {10'd0, cur_len};
    assign sat     = sum[25] ? '1 : sum[24:0];
    assign left    = limit - sat[23:0];
    assign on_fix  = (cmd.on_ticks == 16'd0) ? 16'd1 : cmd.on_ticks;
    assign off_fix = (cmd.off_ticks == 16'd0) ? 16'd1 : cmd.off_ticks;

    always_comb begin
      steady_next    = steady;
      pin_next       = pin;
      active_next    = active;
      phase_on_next  = phase_on;
      on_len_next    = on_len;
      off_len_next   = off_len;
      limit_next     = limit;
      elapsed_next   = elapsed;
      countdown_next = countdown;
      if (push) begin
        unique case (cmd.operation)
          OP_TICK: begin
            if (active) begin
              if (countdown <= 16'd1) begin
                // phase expires: toggle and charge the full nominal length
                pin_next      = !phase_on;
                phase_on_next = !phase_on;
                elapsed_next  = sat;
                if (limit == 24'd0) begin
                  countdown_next = nxt_len;
                end else if (sat >= {1'b0, limit}) begin
                  active_next  = 1'b0;
                  elapsed_next = '0;
                  limit_next   = '0;
                  pin_next     = steady;
                end else begin
                  // cut the last phase short at the timeout
                  countdown_next = ({8'd0, nxt_len} > left) ? left[15:0] : nxt_len;
                end
              end else begin
                countdown_next = countdown - 16'd1;
              end
            end
          end
          OP_SET_ON: begin
            if (sel) begin
              steady_next = 1'b1;
              pin_next    = 1'b1;
            end
          end
          OP_SET_OFF: begin
            if (sel) begin
              steady_next = 1'b0;
              pin_next    = 1'b0;
            end
          end
          OP_START: begin
            if (sel) begin
              on_len_next    = on_fix;
              off_len_next   = off_fix;
              phase_on_next  = steady;
              active_next    = 1'b1;
              elapsed_next   = '0;
              limit_next     = cmd.timeout_ticks;
              countdown_next = steady ? on_fix : off_fix;
            end
          end
          OP_STOP: begin
            if (sel) begin
              active_next  = 1'b0;
              elapsed_next = '0;
              limit_next   = '0;
              pin_next     = steady;
            end
          end
          default: begin
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        steady    <= 1'b0;
        pin       <= 1'b0;
        active    <= 1'b0;
        phase_on  <= 1'b0;
        limit     <= '0;
        elapsed   <= '0;
        countdown <= '0;
      end else begin
        steady    <= steady_next;
        pin       <= pin_next;
        active    <= active_next;
        phase_on  <= phase_on_next;
        limit     <= limit_next;
        elapsed   <= elapsed_next;
        countdown <= countdown_next;
      end
    end

    always_ff @(posedge clk) begin
      on_len  <= on_len_next;
      off_len <= off_len_next;
    end

    assign pin_q[i]           = pin;
    assign steady_q[i]        = steady;
    assign active_q[i]        = active;
    assign pin_vec_next[i]    = pin_next;
    assign active_vec_next[i] = active_next;
  end

  always_comb begin
    result.pin_levels  = MaxLeds'(pin_vec_next);
    result.blink_flags = MaxLeds'(active_vec_next);
    result.bad_index   = bad;
  end

  // two-word result buffer: head drives the port, skid catches a word during a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fill == 2'd2) begin
      if (pop) begin
        head <= skid;
      end
    end else if (fill == 2'd1) begin
      if (push && pop) begin
        head <= result;
      end else if (push) begin
        skid <= result;
      end
    end else if (push) begin
      head <= result;
    end
  end

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("result buffer fill out of range");

  a_skid_advance : assert property (@(posedge clk) disable iff (rst)
    (pop && (fill == 2'd2)) |=> (status == $past(skid)))
    else $error("held word not advanced to head");

  a_idle_pin : assert property (@(posedge clk) disable iff (rst)
    ((pin_q ^ steady_q) & ~active_q) == '0)
    else $error("idle LED pin differs from steady level");

  a_push_fill : assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> status_valid)
    else $error("accepted word produced no result");

endmodule
`default_nettype wire
